// ===== rtl/sbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the smart beacon scheduler
// Field widths, time and angle constants, cause codes, register indexes and
// sequencer states.
// ----------------------------------------------------------------------------
package sbs_pkg;

   // field widths
   localparam int NOW_W     = 32;
   localparam int SPEED_W   = 12;
   localparam int HEAD_W    = 13;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CAUSE_W   = 2;

   // knots to km/h in thousandths: speed * 1852
   localparam int KNOT_MUL   = 1852;
   localparam int KNOT_MUL_W = 11;
   localparam int S_W        = SPEED_W + KNOT_MUL_W;
   localparam int KMH_MILLI  = 1000;

   // intervals in ms stay below 2^24
   localparam int TIME_W      = 24;
   localparam int CNT_W       = $clog2(TIME_W);
   localparam int MS_PER_MIN  = 60000;
   localparam int MS_PER_S    = 1000;
   localparam int TURN_GAP_MS = 5000;
   localparam logic [NOW_W-1:0] LAST_RESET = 32'hFFF0_0000;

   // angles in 1/16 degree
   localparam int DEG_FRAC     = 4;
   localparam int HALF_TURN_Q4 = 2880;
   localparam int FULL_TURN_Q4 = 5760;
   localparam int HD_W         = HEAD_W + 2;
   localparam int MIN_TURN_KMH = 2;
   // turn slope quotient is at most 255 * 16 / 2
   localparam int TQ_W         = 11;

   // register reset values
   localparam logic                RST_SMART_MODE = 1'b1;
   localparam logic [CFG_W-1:0]    RST_FIXED_MIN  = 8'd10;
   localparam logic [CFG_W-1:0]    RST_LOW_KMH    = 8'd5;
   localparam logic [CFG_W-1:0]    RST_HIGH_KMH   = 8'd90;
   localparam logic [CFG_W-1:0]    RST_SLOW_MIN   = 8'd30;
   localparam logic [CFG_W-1:0]    RST_FAST_S     = 8'd60;
   localparam logic [CFG_W-1:0]    RST_TURN_MIN   = 8'd28;
   localparam logic [CFG_W-1:0]    RST_TURN_SLOPE = 8'd255;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_FIXED = 2'd1,
      CAUSE_SMART = 2'd2,
      CAUSE_TURN  = 2'd3
   } cause_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMART_MODE  = 3'd0,
      CSR_FIXED_MIN   = 3'd1,
      CSR_LOW_KMH     = 3'd2,
      CSR_HIGH_KMH    = 3'd3,
      CSR_SLOW_MIN    = 3'd4,
      CSR_FAST_S      = 3'd5,
      CSR_TURN_MIN    = 3'd6,
      CSR_TURN_SLOPE  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_INTERP,
      ST_TURN,
      ST_TURNCHK,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/sbs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs_if: item channels of the smart beacon scheduler
// Position update channel and beacon decision channel, valid/ready.
// ----------------------------------------------------------------------------
interface sbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [sbs_pkg::NOW_W-1:0]    now_ms;
   logic [sbs_pkg::SPEED_W-1:0]  speed_knots_q4;
   logic [sbs_pkg::HEAD_W-1:0]   heading_q4;
   logic                         fix_valid;

   modport source (output valid, output now_ms, output speed_knots_q4,
                   output heading_q4, output fix_valid, input ready);
   modport sink   (input valid, input now_ms, input speed_knots_q4,
                   input heading_q4, input fix_valid, output ready);
endinterface

interface sbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         transmit;
   logic [sbs_pkg::CAUSE_W-1:0]  cause;

   modport source (output valid, output transmit, output cause, input ready);
   modport sink   (input valid, input transmit, input cause, output ready);
endinterface

// ===== rtl/smart_beacon_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smart_beacon_scheduler_core: position beacon timing decision
// Fixed interval or speed and turn based beaconing, one decision per update.
// ----------------------------------------------------------------------------
// Usage:
//   req_port takes one position update item (time, speed, heading, fix flag);
//   rsp_port returns one decision item (transmit, cause) per update, in order.
//   csr_we/csr_index/csr_wdata write the eight setup registers; write them
//   only while no update is in flight.
//   Invalid fixes and fixed mode need no arithmetic; a speed outside the
//   interpolation band may run only the turn check, and a speed inside the
//   band runs the band multiply and divide, then possibly the turn check.
//   All of it runs on one bit-serial shift-add and restoring divide unit:
//   24 steps for the band multiply, 24 for the band divide and 11 for the
//   turn threshold divide.
//   One update is processed at a time; the next item is accepted the cycle
//   after the result is loaded into the output register.
//   A stalled receiver holds the result in the output register; the next
//   update is still accepted and computed, and waits only at its own result.
//   Synchronous reset restores the register defaults, sets the last beacon
//   time to 0xFFF00000 and the last heading to zero, and drops any result.
// ----------------------------------------------------------------------------
module smart_beacon_scheduler_core #(
   parameter int SPEED_FRAC_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   sbs_req_if.sink                       req_port,
   sbs_rsp_if.source                     rsp_port,
   input  logic                          csr_we,
   input  logic [sbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbs_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int KMH_UNIT   = sbs_pkg::KMH_MILLI << SPEED_FRAC_BITS;
   localparam int UNIT_W     = $clog2(sbs_pkg::KMH_MILLI) + SPEED_FRAC_BITS;
   localparam int LIM_W      = sbs_pkg::CFG_W + UNIT_W;
   localparam int CMP_W      = (sbs_pkg::S_W > LIM_W) ? sbs_pkg::S_W : LIM_W;
   localparam int PROD_W     = sbs_pkg::S_W + sbs_pkg::TIME_W;
   localparam int SHL_W      = LIM_W + sbs_pkg::TIME_W - 1;
   localparam int ACC_W      = (PROD_W > SHL_W) ? PROD_W : SHL_W;
   localparam int TURN_UNIT  = KMH_UNIT << sbs_pkg::DEG_FRAC;
   localparam logic [CMP_W-1:0] TURN_SPEED = CMP_W'(sbs_pkg::MIN_TURN_KMH * KMH_UNIT);
   localparam logic signed [sbs_pkg::HD_W-1:0] HALF_S = sbs_pkg::HD_W'(sbs_pkg::HALF_TURN_Q4);
   localparam logic signed [sbs_pkg::HD_W-1:0] FULL_S = sbs_pkg::HD_W'(sbs_pkg::FULL_TURN_Q4);

   // configuration
   logic                         smart_mode_ff;
   logic [sbs_pkg::CFG_W-1:0]    fixed_interval_min_ff;
   logic [sbs_pkg::CFG_W-1:0]    low_speed_kmh_ff;
   logic [sbs_pkg::CFG_W-1:0]    high_speed_kmh_ff;
   logic [sbs_pkg::CFG_W-1:0]    slow_rate_min_ff;
   logic [sbs_pkg::CFG_W-1:0]    fast_rate_s_ff;
   logic [sbs_pkg::CFG_W-1:0]    turn_min_deg_ff;
   logic [sbs_pkg::CFG_W-1:0]    turn_slope_ff;

   // beacon state
   logic [sbs_pkg::NOW_W-1:0]    last_beacon_ff;
   logic [sbs_pkg::HEAD_W-1:0]   last_head_ff;

   // captured update
   logic [sbs_pkg::NOW_W-1:0]    now_ff;
   logic [sbs_pkg::SPEED_W-1:0]  speed_ff;
   logic [sbs_pkg::HEAD_W-1:0]   head_ff;
   logic                         fix_ff;

   // sequencer and serial unit
   sbs_pkg::state_type           st_ff, st_in;
   sbs_pkg::cause_type           cause_ff, cause_in;
   logic [sbs_pkg::S_W-1:0]      s_ff, s_in;
   logic [sbs_pkg::NOW_W-1:0]    elapsed_ff, elapsed_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [ACC_W-1:0]             dsh_ff, dsh_in;
   logic [sbs_pkg::TIME_W-1:0]   quo_ff, quo_in;
   logic [sbs_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_transmit_ff;
   logic [sbs_pkg::CAUSE_W-1:0]  rsp_cause_ff;

   logic                         req_fire;
   logic                         out_free;
   logic                         done_fire;

   logic [CMP_W-1:0]             s_c, lo_c, hi_c;
   logic                         below_lo, at_hi, in_band;
   logic [sbs_pkg::TIME_W-1:0]   slow_ms, fast_ms, fixed_ms, span, edge_ms, band_ms;
   logic                         slow_ge_fast;
   logic                         fixed_due, edge_due, band_due, turn_ok;
   logic [ACC_W-1:0]             mcand_init, kspan_sh, turn_num, turn_dsh;
   logic                         div_ge;
   logic signed [sbs_pkg::HD_W-1:0] hd_raw, hd_wrap1, hd_wrap2, hd_abs;
   logic [sbs_pkg::HD_W-1:0]     turn_thr;
   logic                         turn_seen;

   assign req_fire  = req_port.valid && req_port.ready;
   assign req_port.ready = (st_ff == sbs_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign done_fire = (st_ff == sbs_pkg::ST_DONE) && out_free;

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.transmit = rsp_transmit_ff;
   assign rsp_port.cause    = rsp_cause_ff;

   // speed limits and intervals
   assign s_c      = CMP_W'(s_ff);
   assign lo_c     = CMP_W'(LIM_W'(low_speed_kmh_ff) * LIM_W'(KMH_UNIT));
   assign hi_c     = CMP_W'(LIM_W'(high_speed_kmh_ff) * LIM_W'(KMH_UNIT));
   assign below_lo = s_c < lo_c;
   assign at_hi    = s_c >= hi_c;
   assign in_band  = !below_lo && !at_hi;

   assign slow_ms  = sbs_pkg::TIME_W'(slow_rate_min_ff)
                   * sbs_pkg::TIME_W'(sbs_pkg::MS_PER_MIN);
   assign fast_ms  = sbs_pkg::TIME_W'(fast_rate_s_ff)
                   * sbs_pkg::TIME_W'(sbs_pkg::MS_PER_S);
   assign fixed_ms = sbs_pkg::TIME_W'(fixed_interval_min_ff)
                   * sbs_pkg::TIME_W'(sbs_pkg::MS_PER_MIN);
   assign slow_ge_fast = slow_ms >= fast_ms;
   assign span     = slow_ge_fast ? (slow_ms - fast_ms) : (fast_ms - slow_ms);
   assign edge_ms  = below_lo ? slow_ms : fast_ms;
   assign band_ms  = slow_ge_fast ? (slow_ms - quo_ff) : (slow_ms + quo_ff);

   assign fixed_due = elapsed_ff >= sbs_pkg::NOW_W'(fixed_ms);
   assign edge_due  = elapsed_ff >= sbs_pkg::NOW_W'(edge_ms);
   assign band_due  = elapsed_ff >= sbs_pkg::NOW_W'(band_ms);
   assign turn_ok   = (elapsed_ff >= sbs_pkg::NOW_W'(sbs_pkg::TURN_GAP_MS))
                   && (s_c >= TURN_SPEED);

   // operand loads of the serial unit
   assign mcand_init = ACC_W'(s_c - lo_c);
   assign kspan_sh   = ACC_W'(hi_c - lo_c) << (sbs_pkg::TIME_W - 1);
   assign turn_num   = ACC_W'(turn_slope_ff) * ACC_W'(TURN_UNIT);
   assign turn_dsh   = ACC_W'(s_ff) << (sbs_pkg::TQ_W - 1);
   assign div_ge     = acc_ff >= dsh_ff;

   // heading change, single-step wrap
   always_comb begin
      hd_raw   = $signed({2'b00, head_ff}) - $signed({2'b00, last_head_ff});
      hd_wrap1 = (hd_raw > HALF_S) ? (hd_raw - FULL_S) : hd_raw;
      hd_wrap2 = (hd_wrap1 < -HALF_S) ? (hd_wrap1 + FULL_S) : hd_wrap1;
      hd_abs   = (hd_wrap2 < 0) ? -hd_wrap2 : hd_wrap2;
   end

   assign turn_thr  = (sbs_pkg::HD_W'(turn_min_deg_ff) << sbs_pkg::DEG_FRAC)
                    + sbs_pkg::HD_W'(quo_ff[sbs_pkg::TQ_W-1:0]);
   assign turn_seen = $unsigned(hd_abs) >= turn_thr;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         sbs_pkg::ST_IDLE: begin
            if (req_fire) st_in = sbs_pkg::ST_PREP;
         end
         sbs_pkg::ST_PREP: st_in = sbs_pkg::ST_EVAL;
         sbs_pkg::ST_EVAL: begin
            priority if (!fix_ff || !smart_mode_ff) st_in = sbs_pkg::ST_DONE;
            else if (in_band)                       st_in = sbs_pkg::ST_MUL;
            else if (edge_due)                      st_in = sbs_pkg::ST_DONE;
            else if (turn_ok)                       st_in = sbs_pkg::ST_TURN;
            else                                    st_in = sbs_pkg::ST_DONE;
         end
         sbs_pkg::ST_MUL: begin
            if (cnt_ff == '0) st_in = sbs_pkg::ST_DIV;
         end
         sbs_pkg::ST_DIV: begin
            if (cnt_ff == '0) st_in = sbs_pkg::ST_INTERP;
         end
         sbs_pkg::ST_INTERP: begin
            priority if (band_due) st_in = sbs_pkg::ST_DONE;
            else if (turn_ok)      st_in = sbs_pkg::ST_TURN;
            else                   st_in = sbs_pkg::ST_DONE;
         end
         sbs_pkg::ST_TURN: begin
            if (cnt_ff == '0) st_in = sbs_pkg::ST_TURNCHK;
         end
         sbs_pkg::ST_TURNCHK: st_in = sbs_pkg::ST_DONE;
         sbs_pkg::ST_DONE: begin
            if (out_free) st_in = sbs_pkg::ST_IDLE;
         end
         default: st_in = sbs_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      s_in       = s_ff;
      elapsed_in = elapsed_ff;
      acc_in     = acc_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      cause_in   = cause_ff;
      unique case (st_ff)
         sbs_pkg::ST_PREP: begin
            s_in       = sbs_pkg::S_W'(speed_ff) * sbs_pkg::S_W'(sbs_pkg::KNOT_MUL);
            elapsed_in = now_ff - last_beacon_ff;
            cause_in   = sbs_pkg::CAUSE_NONE;
         end
         sbs_pkg::ST_EVAL: begin
            priority if (!fix_ff) begin
               cause_in = sbs_pkg::CAUSE_NONE;
            end else if (!smart_mode_ff) begin
               cause_in = fixed_due ? sbs_pkg::CAUSE_FIXED : sbs_pkg::CAUSE_NONE;
            end else if (in_band) begin
               acc_in = '0;
               dsh_in = mcand_init;
               quo_in = span;
               cnt_in = sbs_pkg::CNT_W'(sbs_pkg::TIME_W - 1);
            end else if (edge_due) begin
               cause_in = sbs_pkg::CAUSE_SMART;
            end else if (turn_ok) begin
               acc_in = turn_num;
               dsh_in = turn_dsh;
               quo_in = '0;
               cnt_in = sbs_pkg::CNT_W'(sbs_pkg::TQ_W - 1);
            end else begin
               cause_in = sbs_pkg::CAUSE_NONE;
            end
         end
         sbs_pkg::ST_MUL: begin
            // shift-add, multiplier bits LSB first
            if (quo_ff[0]) acc_in = acc_ff + dsh_ff;
            dsh_in = dsh_ff << 1;
            quo_in = quo_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dsh_in = kspan_sh;
               quo_in = '0;
               cnt_in = sbs_pkg::CNT_W'(sbs_pkg::TIME_W - 1);
            end
         end
         sbs_pkg::ST_DIV, sbs_pkg::ST_TURN: begin
            // restoring step, one quotient bit per cycle
            if (div_ge) acc_in = acc_ff - dsh_ff;
            quo_in = {quo_ff[sbs_pkg::TIME_W-2:0], div_ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         sbs_pkg::ST_INTERP: begin
            priority if (band_due) begin
               cause_in = sbs_pkg::CAUSE_SMART;
            end else if (turn_ok) begin
               acc_in = turn_num;
               dsh_in = turn_dsh;
               quo_in = '0;
               cnt_in = sbs_pkg::CNT_W'(sbs_pkg::TQ_W - 1);
            end else begin
               cause_in = sbs_pkg::CAUSE_NONE;
            end
         end
         sbs_pkg::ST_TURNCHK: begin
            cause_in = turn_seen ? sbs_pkg::CAUSE_TURN : sbs_pkg::CAUSE_NONE;
         end
         sbs_pkg::ST_IDLE, sbs_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sbs_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      elapsed_ff <= elapsed_in;
      acc_ff     <= acc_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      cause_ff   <= cause_in;
      if (req_fire) begin
         now_ff   <= req_port.now_ms;
         speed_ff <= req_port.speed_knots_q4;
         head_ff  <= req_port.heading_q4;
         fix_ff   <= req_port.fix_valid;
      end
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_transmit_ff <= (cause_ff != sbs_pkg::CAUSE_NONE);
         rsp_cause_ff    <= cause_ff;
      end
   end

   // commit the beacon on transmit
   always_ff @(posedge clock) begin
      if (reset) begin
         last_beacon_ff <= sbs_pkg::LAST_RESET;
         last_head_ff   <= '0;
      end else if (done_fire && (cause_ff != sbs_pkg::CAUSE_NONE)) begin
         last_beacon_ff <= now_ff;
         last_head_ff   <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smart_mode_ff         <= sbs_pkg::RST_SMART_MODE;
         fixed_interval_min_ff <= sbs_pkg::RST_FIXED_MIN;
         low_speed_kmh_ff      <= sbs_pkg::RST_LOW_KMH;
         high_speed_kmh_ff     <= sbs_pkg::RST_HIGH_KMH;
         slow_rate_min_ff      <= sbs_pkg::RST_SLOW_MIN;
         fast_rate_s_ff        <= sbs_pkg::RST_FAST_S;
         turn_min_deg_ff       <= sbs_pkg::RST_TURN_MIN;
         turn_slope_ff         <= sbs_pkg::RST_TURN_SLOPE;
      end else if (csr_we) begin
         unique case (sbs_pkg::csr_index_type'(csr_index))
            sbs_pkg::CSR_SMART_MODE: smart_mode_ff         <= csr_wdata[0];
            sbs_pkg::CSR_FIXED_MIN:  fixed_interval_min_ff <= csr_wdata;
            sbs_pkg::CSR_LOW_KMH:    low_speed_kmh_ff      <= csr_wdata;
            sbs_pkg::CSR_HIGH_KMH:   high_speed_kmh_ff     <= csr_wdata;
            sbs_pkg::CSR_SLOW_MIN:   slow_rate_min_ff      <= csr_wdata;
            sbs_pkg::CSR_FAST_S:     fast_rate_s_ff        <= csr_wdata;
            sbs_pkg::CSR_TURN_MIN:   turn_min_deg_ff       <= csr_wdata;
            sbs_pkg::CSR_TURN_SLOPE: turn_slope_ff         <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (done_fire && (cause_ff != sbs_pkg::CAUSE_NONE)) |=>
         ((last_beacon_ff == $past(now_ff)) && (last_head_ff == $past(head_ff))))
      else $error("beacon state not committed on transmit");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == sbs_pkg::ST_DIV) || (st_ff == sbs_pkg::ST_TURN)) |->
         ({1'b0, acc_ff} < {dsh_ff, 1'b0}))
      else $error("divider remainder out of range");

   a_turn_quo: assert property (@(posedge clock) disable iff (reset)
      (st_ff == sbs_pkg::ST_TURNCHK) |->
         (quo_ff[sbs_pkg::TIME_W-1:sbs_pkg::TQ_W] == '0))
      else $error("turn quotient overflow");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_transmit_ff == (rsp_cause_ff != sbs_pkg::CAUSE_NONE)))
      else $error("transmit flag disagrees with cause");
`endif

endmodule
